/* hdl/crchk_pkg.sv */
// shared constants, types and crc function for the settings record checker
package crchk_pkg;

  localparam logic [7:0]  MAGIC_HI    = 8'hA5;
  localparam logic [7:0]  MAGIC_LO    = 8'h5A;
  localparam int          BODY_BYTES  = 2 + 2 + 2 + 1 + 1 + 4;
  localparam logic [7:0]  LEN_BYTE    = 8'(BODY_BYTES);
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  localparam int POS_W = 5;
  localparam int IDX_W = $clog2(BODY_BYTES);

  // byte offsets inside the record
  localparam logic [POS_W-1:0] OFS_MAGIC_HI  = 5'd0;
  localparam logic [POS_W-1:0] OFS_MAGIC_LO  = 5'd1;
  localparam logic [POS_W-1:0] OFS_VERSION   = 5'd2;
  localparam logic [POS_W-1:0] OFS_LENGTH    = 5'd3;
  localparam logic [POS_W-1:0] OFS_PAYLOAD   = 5'd4;
  localparam logic [POS_W-1:0] OFS_CRC_LOW   = 5'd16;
  localparam logic [POS_W-1:0] OFS_LAST      = 5'd17;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_READ   = 3'd1,
    ST_MAGIC  = 3'd2,
    ST_VERLEN = 3'd3,
    ST_CRC    = 3'd4
  } status_t;

  typedef struct packed {
    status_t            status;
    logic signed [15:0] temp_high;
    logic signed [15:0] temp_low;
    logic [15:0]        cooldown_seconds;
    logic [7:0]         default_mode;
    logic [7:0]         schedule_entries;
    logic [31:0]        boot_total;
  } result_t;

  // reflected crc-16 over one byte, lsb first
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* hdl/crchk_track.sv */
// record tracker: byte position, running crc, first error (a read failure overrides it) and payload bytes
module crchk_track (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [7:0]               data_byte,
  input  logic                     first,
  input  logic                     read_failed,
  input  logic [7:0]               expected_version,
  output logic                     at_last,
  output logic                     res_valid,
  output crchk_pkg::result_t       res
);

  logic [crchk_pkg::POS_W-1:0] pos;
  logic [crchk_pkg::POS_W-1:0] pos_next;
  logic [15:0]                 crc;
  logic [15:0]                 crc_next;
  crchk_pkg::status_t          err;
  crchk_pkg::status_t          err_next;
  logic [7:0]                  payload [crchk_pkg::BODY_BYTES];
  logic [7:0]                  crc_low;

  logic [crchk_pkg::POS_W-1:0] pos_eff;
  logic [15:0]                 crc_base;
  crchk_pkg::status_t          err_base;
  crchk_pkg::status_t          err_step;
  crchk_pkg::status_t          hdr_code;
  logic                        last_byte;
  logic                        in_payload;
  logic [crchk_pkg::POS_W-1:0] pld_ofs;
  logic [crchk_pkg::IDX_W-1:0] pld_idx;

  assign at_last = (pos == crchk_pkg::OFS_LAST);

  always_comb begin
    logic restart;
    restart  = first || (pos > crchk_pkg::OFS_LAST);
    pos_eff  = restart ? '0 : pos;
    crc_base = restart ? crchk_pkg::CRC_INIT : crc;
    err_base = restart ? crchk_pkg::ST_OK : err;

    last_byte  = (pos_eff == crchk_pkg::OFS_LAST);
    in_payload = (pos_eff >= crchk_pkg::OFS_PAYLOAD) && (pos_eff < crchk_pkg::OFS_CRC_LOW);
    pld_ofs    = pos_eff - crchk_pkg::OFS_PAYLOAD;
    pld_idx    = pld_ofs[crchk_pkg::IDX_W-1:0];

    hdr_code = crchk_pkg::ST_OK;
    case (pos_eff)
      crchk_pkg::OFS_MAGIC_HI: begin
        if (data_byte != crchk_pkg::MAGIC_HI) hdr_code = crchk_pkg::ST_MAGIC;
      end
      crchk_pkg::OFS_MAGIC_LO: begin
        if (data_byte != crchk_pkg::MAGIC_LO) hdr_code = crchk_pkg::ST_MAGIC;
      end
      crchk_pkg::OFS_VERSION: begin
        if (data_byte != expected_version) hdr_code = crchk_pkg::ST_VERLEN;
      end
      crchk_pkg::OFS_LENGTH: begin
        if (data_byte != crchk_pkg::LEN_BYTE) hdr_code = crchk_pkg::ST_VERLEN;
      end
      crchk_pkg::OFS_LAST: begin
        if ({data_byte, crc_low} != crc_base) hdr_code = crchk_pkg::ST_CRC;
      end
      default: begin
        hdr_code = crchk_pkg::ST_OK;
      end
    endcase

    // read failure overrides, otherwise the earliest error sticks
    err_step = read_failed ? crchk_pkg::ST_READ : err_base;
    if (err_step == crchk_pkg::ST_OK) begin
      err_step = hdr_code;
    end

    crc_next = (pos_eff < crchk_pkg::OFS_CRC_LOW) ?
               crchk_pkg::crc_update(crc_base, data_byte) : crc_base;

    pos_next = last_byte ? '0 : pos_eff + 1'b1;
    err_next = last_byte ? crchk_pkg::ST_OK : err_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      crc <= crchk_pkg::CRC_INIT;
      err <= crchk_pkg::ST_OK;
    end else if (accept) begin
      pos <= pos_next;
      crc <= last_byte ? crchk_pkg::CRC_INIT : crc_next;
      err <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_payload) begin
      payload[pld_idx] <= data_byte;
    end
    if (accept && (pos_eff == crchk_pkg::OFS_CRC_LOW)) begin
      crc_low <= data_byte;
    end
  end

  assign res_valid = accept && last_byte;

  always_comb begin
    res        = '0;
    res.status = err_step;
    if (err_step == crchk_pkg::ST_OK) begin
      res.temp_high        = {payload[1], payload[0]};
      res.temp_low         = {payload[3], payload[2]};
      res.cooldown_seconds = {payload[5], payload[4]};
      res.default_mode     = payload[6];
      res.schedule_entries = payload[7];
      res.boot_total       = {payload[11], payload[10], payload[9], payload[8]};
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= crchk_pkg::OFS_LAST)
    else $error("byte position out of range");

  a_result_only_at_end: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (pos == crchk_pkg::OFS_LAST) && !first)
    else $error("result outside the last offset");

  a_wrap_after_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> (pos == '0) && (crc == crchk_pkg::CRC_INIT) &&
                  (err == crchk_pkg::ST_OK))
    else $error("record state not cleared after result");

endmodule

/* hdl/crchk_out.sv */
// result register and input ready control
module crchk_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                at_last,
  input  logic                res_valid,
  input  crchk_pkg::result_t  res,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output crchk_pkg::result_t  out_res
);

  // only a byte at the last offset can produce a result, so stall just that one
  assign in_ready = !out_valid || out_ready || !at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

endmodule

/* hdl/config_record_checker.sv */
// Settings record checker takes one record byte per cycle unless stalled (in_valid/in_ready)
// and, after the eighteenth byte, presents one result with status and decoded fields
// (out_valid/out_ready). The crc byte update, header compares and payload capture all
// complete in the cycle of the transfer, and the result is then registered in the output
// register. in_ready drops only for a byte at the last record offset while an earlier result
// is still waiting in the output register. first restarts a record; records may also follow
// one another without it. expected_version (reset 1) is written through cfg_we/cfg_wdata.
module config_record_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               first,
  input  logic               read_failed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [15:0] temp_high,
  output logic signed [15:0] temp_low,
  output logic [15:0]        cooldown_seconds,
  output logic [7:0]         default_mode,
  output logic [7:0]         schedule_entries,
  output logic [31:0]        boot_total
);

  logic [7:0]          expected_version;
  logic                accept;
  logic                at_last;
  logic                res_valid;
  crchk_pkg::result_t  res;
  crchk_pkg::result_t  out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= 8'd1;
    end else if (cfg_we) begin
      expected_version <= cfg_wdata;
    end
  end

  assign accept = in_valid && in_ready;

  crchk_track u_track (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .data_byte        (data_byte),
    .first            (first),
    .read_failed      (read_failed),
    .expected_version (expected_version),
    .at_last          (at_last),
    .res_valid        (res_valid),
    .res              (res)
  );

  crchk_out u_out (
    .clk       (clk),
    .rst       (rst),
    .at_last   (at_last),
    .res_valid (res_valid),
    .res       (res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign status           = out_res.status;
  assign temp_high        = out_res.temp_high;
  assign temp_low         = out_res.temp_low;
  assign cooldown_seconds = out_res.cooldown_seconds;
  assign default_mode     = out_res.default_mode;
  assign schedule_entries = out_res.schedule_entries;
  assign boot_total       = out_res.boot_total;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(out_valid && !out_ready))
    else $error("pending result overwritten");

  a_fields_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.status != crchk_pkg::ST_OK)) |->
      (temp_high == '0) && (temp_low == '0) && (cooldown_seconds == '0) &&
      (default_mode == '0) && (schedule_entries == '0) && (boot_total == '0))
    else $error("fields not cleared on error status");

endmodule

/* test/tb.sv */
// testbench for the settings record checker: directed record table, then random records
module tb;
  import crchk_pkg::*;

  // fault marks used to build broken records
  localparam logic [4:0] F_NONE     = 5'b00000;
  localparam logic [4:0] F_MAGIC_HI = 5'b00001;
  localparam logic [4:0] F_MAGIC_LO = 5'b00010;
  localparam logic [4:0] F_VER      = 5'b00100;
  localparam logic [4:0] F_LEN      = 5'b01000;
  localparam logic [4:0] F_CRC      = 5'b10000;
  localparam int         NO_FAIL    = -1;
  localparam int         N_DIR      = 18;

  localparam logic [95:0] P_ZERO = 96'h0;
  localparam logic [95:0] P_ONES = {96{1'b1}};
  localparam logic [95:0] P_EXT  = 96'h80000001_7F80_0001_8000_7FFF;
  localparam logic [95:0] P_MIX  = 96'h01234567_89AB_CDEF_0011_2233;
  localparam logic [95:0] P_ALT  = 96'hDEADBEEF_1234_5678_9ABC_DEF0;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       rf;
    logic       typed;
    result_t    want;
  } byte_item_t;

  typedef struct packed {
    logic        wr_cfg;
    logic [7:0]  cfg_val;
    logic [95:0] body;
    logic [7:0]  ver;
    logic [4:0]  faults;
    logic        mark;
    int          fail_ofs;
    int          from_ofs;
    int          to_ofs;
    logic        typed;
    result_t     want;
  } rec_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [7:0]         cfg_wdata = 8'h00;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         data_byte = 8'h00;
  logic               first = 1'b0;
  logic               read_failed = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic [2:0]         status;
  logic signed [15:0] temp_high;
  logic signed [15:0] temp_low;
  logic [15:0]        cooldown_seconds;
  logic [7:0]         default_mode;
  logic [7:0]         schedule_entries;
  logic [31:0]        boot_total;

  // travels alongside the byte so the monitor knows a typed-in expectation
  logic               in_typed = 1'b0;
  result_t            in_want = '0;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int mismatches = 0;
  bit aligned = 1'b1;

  byte_item_t byte_q[$];
  result_t    pending_results[$];
  logic [7:0] rec_bytes [18];
  rec_row_t   dir_rows [N_DIR];

  // checker's own copy of the record state
  logic [7:0]  version_reg = 8'h01;
  logic [4:0]  rec_pos = '0;
  logic [15:0] rec_crc = CRC_INIT;
  status_t     rec_err = ST_OK;
  logic [7:0]  rec_body [BODY_BYTES];
  logic [7:0]  crc_lo_seen = 8'h00;

  config_record_checker dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .first            (first),
    .read_failed      (read_failed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .temp_high        (temp_high),
    .temp_low         (temp_low),
    .cooldown_seconds (cooldown_seconds),
    .default_mode     (default_mode),
    .schedule_entries (schedule_entries),
    .boot_total       (boot_total)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // modbus crc, one message bit at a time
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c = {1'b0, c[15:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic result_t bare_status(input status_t s);
    result_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  task automatic compare_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      report_error($sformatf("result with nothing pending, status %0d", got.status));
      return;
    end
    want = pending_results.pop_front();
    cmp_field("status", 32'(got.status), 32'(want.status));
    cmp_field("temp_high", 32'(got.temp_high), 32'(want.temp_high));
    cmp_field("temp_low", 32'(got.temp_low), 32'(want.temp_low));
    cmp_field("cooldown_seconds", 32'(got.cooldown_seconds), 32'(want.cooldown_seconds));
    cmp_field("default_mode", 32'(got.default_mode), 32'(want.default_mode));
    cmp_field("schedule_entries", 32'(got.schedule_entries), 32'(want.schedule_entries));
    cmp_field("boot_total", got.boot_total, want.boot_total);
  endtask

  // advance the record state by one byte; done is set after the last offset
  task automatic track_record_byte(input logic [7:0] d, input logic mark, input logic rf,
                                   output logic done, output result_t res);
    logic [4:0]  p;
    logic [15:0] stored;
    if (mark || rec_pos > OFS_LAST) begin
      rec_pos = '0;
      rec_crc = CRC_INIT;
      rec_err = ST_OK;
    end
    p = rec_pos;
    done = 1'b0;
    res = '0;
    if (rf) rec_err = ST_READ;
    if (p < OFS_CRC_LOW) rec_crc = crc16_step(rec_crc, d);
    case (p)
      OFS_MAGIC_HI: if (d != MAGIC_HI && rec_err == ST_OK) rec_err = ST_MAGIC;
      OFS_MAGIC_LO: if (d != MAGIC_LO && rec_err == ST_OK) rec_err = ST_MAGIC;
      OFS_VERSION: if (d != version_reg && rec_err == ST_OK) rec_err = ST_VERLEN;
      OFS_LENGTH: if (d != LEN_BYTE && rec_err == ST_OK) rec_err = ST_VERLEN;
      OFS_CRC_LOW: crc_lo_seen = d;
      OFS_LAST: ;
      default: rec_body[p - OFS_PAYLOAD] = d;
    endcase
    if (p != OFS_LAST) begin
      rec_pos = p + 5'd1;
    end else begin
      stored = {d, crc_lo_seen};
      if (stored != rec_crc && rec_err == ST_OK) rec_err = ST_CRC;
      res.status = rec_err;
      if (rec_err == ST_OK) begin
        res.temp_high        = {rec_body[1], rec_body[0]};
        res.temp_low         = {rec_body[3], rec_body[2]};
        res.cooldown_seconds = {rec_body[5], rec_body[4]};
        res.default_mode     = rec_body[6];
        res.schedule_entries = rec_body[7];
        res.boot_total       = {rec_body[11], rec_body[10], rec_body[9], rec_body[8]};
      end
      done = 1'b1;
      rec_pos = '0;
      rec_crc = CRC_INIT;
      rec_err = ST_OK;
    end
  endtask

  always @(posedge clk) begin : watch_ports
    logic    done;
    result_t res;
    result_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.status           = status_t'(status);
        got.temp_high        = temp_high;
        got.temp_low         = temp_low;
        got.cooldown_seconds = cooldown_seconds;
        got.default_mode     = default_mode;
        got.schedule_entries = schedule_entries;
        got.boot_total       = boot_total;
        compare_result(got);
      end
      if (in_valid && in_ready) begin
        track_record_byte(data_byte, first, read_failed, done, res);
        if (done) pending_results.push_back(in_typed ? in_want : res);
      end
    end
  end

  task automatic build_record(input logic [95:0] body, input logic [7:0] ver,
                              input logic [4:0] faults);
    logic [15:0] crc;
    rec_bytes[0] = MAGIC_HI ^ ((faults & F_MAGIC_HI) != 0 ? 8'($urandom_range(1, 255)) : 8'h00);
    rec_bytes[1] = MAGIC_LO ^ ((faults & F_MAGIC_LO) != 0 ? 8'($urandom_range(1, 255)) : 8'h00);
    rec_bytes[2] = ver ^ ((faults & F_VER) != 0 ? 8'($urandom_range(1, 255)) : 8'h00);
    rec_bytes[3] = LEN_BYTE ^ ((faults & F_LEN) != 0 ? 8'($urandom_range(1, 255)) : 8'h00);
    for (int k = 0; k < BODY_BYTES; k++) rec_bytes[4 + k] = body[8*k +: 8];
    crc = CRC_INIT;
    for (int k = 0; k < 16; k++) crc = crc16_step(crc, rec_bytes[k]);
    if ((faults & F_CRC) != 0) crc = crc ^ 16'($urandom_range(1, 65535));
    rec_bytes[16] = crc[7:0];
    rec_bytes[17] = crc[15:8];
  endtask

  task automatic queue_record(input logic mark, input int fail_ofs, input int from_ofs,
                              input int to_ofs, input logic typed, input result_t want);
    byte_item_t it;
    for (int o = from_ofs; o <= to_ofs; o++) begin
      it.data  = rec_bytes[o];
      it.first = mark && (o == 0);
      it.rf    = (o == fail_ofs);
      it.typed = typed && (o == 17);
      it.want  = want;
      byte_q.push_back(it);
    end
  endtask

  task automatic queue_random_record();
    logic [95:0] body;
    logic [4:0]  faults;
    logic        mark;
    byte_item_t  it;
    int          pick;
    int          last;
    int          fail_ofs;
    int          n;
    pick = $urandom_range(99);
    if (pick >= 93) begin
      // stray bytes that leave the record position unknown
      n = $urandom_range(1, 6);
      repeat (n) begin
        it.data  = 8'($urandom);
        it.first = ($urandom_range(3) == 0);
        it.rf    = ($urandom_range(9) == 0);
        it.typed = 1'b0;
        it.want  = '0;
        byte_q.push_back(it);
      end
      aligned = 1'b0;
      return;
    end
    body = {$urandom, $urandom, $urandom};
    faults = (pick >= 60 && pick < 85) ? 5'($urandom_range(1, 31)) : F_NONE;
    last = (pick >= 85) ? $urandom_range(0, 16) : 17;
    fail_ofs = ($urandom_range(99) < 8) ? $urandom_range(0, 17) : NO_FAIL;
    mark = !aligned || ($urandom_range(99) < 70);
    build_record(body, version_reg, faults);
    queue_record(mark, fail_ofs, 0, last, 1'b0, '0);
    aligned = (last == 17);
  endtask

  task automatic drive_all();
    byte_item_t it;
    while (byte_q.size() != 0) begin
      it = byte_q.pop_front();
      while ($urandom_range(99) < src_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid    <= 1'b1;
      data_byte   <= it.data;
      first       <= it.first;
      read_failed <= it.rf;
      in_typed    <= it.typed;
      in_want     <= it.want;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // only between phases: all results in, then a short pause for the pipeline
  task automatic set_version(input logic [7:0] v);
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    version_reg = v;
  endtask

  initial begin
    logic [7:0] v;
    // wr, value, payload, version, faults, mark, read fail, from, to, typed, expected
    dir_rows[0]  = '{1'b0, 8'h00, P_ZERO, 8'h01, F_NONE, 1'b0, NO_FAIL, 0, 17,
                     1'b1, bare_status(ST_OK)};
    dir_rows[1]  = '{1'b0, 8'h00, P_ONES, 8'h01, F_NONE, 1'b1, NO_FAIL, 0, 17, 1'b1,
                     '{ST_OK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF}};
    dir_rows[2]  = '{1'b0, 8'h00, P_EXT, 8'h01, F_NONE, 1'b0, NO_FAIL, 0, 17, 1'b1,
                     '{ST_OK, 16'h7FFF, 16'h8000, 16'h0001, 8'h80, 8'h7F, 32'h8000_0001}};
    dir_rows[3]  = '{1'b0, 8'h00, P_MIX, 8'h01, F_MAGIC_HI, 1'b1, NO_FAIL, 0, 17,
                     1'b1, bare_status(ST_MAGIC)};
    dir_rows[4]  = '{1'b0, 8'h00, P_MIX, 8'h01, F_MAGIC_LO, 1'b1, NO_FAIL, 0, 17,
                     1'b1, bare_status(ST_MAGIC)};
    dir_rows[5]  = '{1'b0, 8'h00, P_MIX, 8'h01, F_VER, 1'b1, NO_FAIL, 0, 17,
                     1'b1, bare_status(ST_VERLEN)};
    dir_rows[6]  = '{1'b0, 8'h00, P_MIX, 8'h01, F_LEN, 1'b1, NO_FAIL, 0, 17,
                     1'b1, bare_status(ST_VERLEN)};
    dir_rows[7]  = '{1'b0, 8'h00, P_MIX, 8'h01, F_CRC, 1'b1, NO_FAIL, 0, 17,
                     1'b1, bare_status(ST_CRC)};
    // read failure on the last byte beats every other error
    dir_rows[8]  = '{1'b0, 8'h00, P_MIX, 8'h01, F_MAGIC_HI | F_VER | F_CRC, 1'b1, 17, 0, 17,
                     1'b1, bare_status(ST_READ)};
    dir_rows[9]  = '{1'b0, 8'h00, P_MIX, 8'h01, F_VER | F_CRC, 1'b1, NO_FAIL, 0, 17,
                     1'b1, bare_status(ST_VERLEN)};
    dir_rows[10] = '{1'b0, 8'h00, P_MIX, 8'h01, F_MAGIC_LO | F_LEN, 1'b1, NO_FAIL, 0, 17,
                     1'b1, bare_status(ST_MAGIC)};
    dir_rows[11] = '{1'b0, 8'h00, P_MIX, 8'h01, F_NONE, 1'b1, 0, 0, 17,
                     1'b1, bare_status(ST_READ)};
    // record cut short, then restarted by the first mark
    dir_rows[12] = '{1'b0, 8'h00, P_ALT, 8'h01, F_NONE, 1'b1, NO_FAIL, 0, 8, 1'b0, '0};
    dir_rows[13] = '{1'b0, 8'h00, P_ALT, 8'h01, F_NONE, 1'b1, NO_FAIL, 0, 17, 1'b0, '0};
    // version register changed between the magic bytes and the version byte
    dir_rows[14] = '{1'b0, 8'h00, P_MIX, 8'h00, F_NONE, 1'b1, NO_FAIL, 0, 1, 1'b0, '0};
    dir_rows[15] = '{1'b1, 8'h00, P_MIX, 8'h00, F_NONE, 1'b1, NO_FAIL, 2, 17, 1'b0, '0};
    dir_rows[16] = '{1'b1, 8'hFF, P_ALT, 8'hFF, F_NONE, 1'b0, NO_FAIL, 0, 17, 1'b0, '0};
    dir_rows[17] = '{1'b0, 8'h00, P_ALT, 8'hFF, F_VER, 1'b1, NO_FAIL, 0, 17,
                     1'b1, bare_status(ST_VERLEN)};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct  = 12;
    snk_stall_pct = 12;
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].wr_cfg) begin
        drive_all();
        set_version(dir_rows[i].cfg_val);
      end
      build_record(dir_rows[i].body, dir_rows[i].ver, dir_rows[i].faults);
      queue_record(dir_rows[i].mark, dir_rows[i].fail_ofs, dir_rows[i].from_ofs,
                   dir_rows[i].to_ofs, dir_rows[i].typed, dir_rows[i].want);
    end
    drive_all();
    aligned = 1'b1;

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: v = 8'h00;
        2: v = 8'hFF;
        5: v = 8'h01;
        default: v = 8'($urandom_range(0, 255));
      endcase
      set_version(v);
      case (ph % 4)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 67;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 67;
        end
        default: begin
          src_idle_pct  = 12;
          snk_stall_pct = 12;
        end
      endcase
      while (byte_q.size() < 85) queue_random_record();
      drive_all();
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2400000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
hdl/crchk_pkg.sv
hdl/crchk_track.sv
hdl/crchk_out.sv
hdl/config_record_checker.sv
test/tb.sv
